// ===== rtl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants for the multikey record sorter.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int COLLEGE_W = 8;
  localparam int DEPT_W    = 8;
  localparam int MEMBER_W  = 16;
  localparam int KEY_W     = COLLEGE_W + DEPT_W + MEMBER_W;

  typedef logic [KEY_W-1:0] key_t;

  // What one cell shows its neighbors: its content and whether that content
  // is strictly greater than the key being inserted this cycle.
  typedef struct packed {
    logic valid;
    key_t key;
    logic gt;
  } link_t;

endpackage

// ===== rtl/mrs_cell.sv =====
// ----------------------------------------------------------------------------
// mrs_cell
// One insertion cell: holds a key, takes the new key or the left neighbor's
// key on insert, takes the right neighbor's key on a drain shift.
// ----------------------------------------------------------------------------
module mrs_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          ins,
  input  logic          shift,
  input  mrs_pkg::key_t new_key,
  input  mrs_pkg::link_t left,
  input  mrs_pkg::link_t right,
  output mrs_pkg::link_t own
);

  logic          valid;
  logic          valid_next;
  mrs_pkg::key_t key;
  mrs_pkg::key_t key_next;
  logic          gt;

  assign gt  = valid && (key > new_key);
  assign own = '{valid: valid, key: key, gt: gt};

  always_comb begin
    priority if (shift) begin
      valid_next = right.valid;
      key_next   = right.key;
    end else if (ins && left.gt) begin
      // left bigger than new key: everything moves one place right
      valid_next = 1'b1;
      key_next   = left.key;
    end else if (ins && (gt || (!valid && left.valid))) begin
      valid_next = 1'b1;
      key_next   = new_key;
    end else begin
      valid_next = valid;
      key_next   = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    key <= key_next;
  end

endmodule

// ===== rtl/multikey_record_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// multikey_record_sorter_unit
// Collects a batch of records and emits it sorted by college, department,
// then member number.
// ----------------------------------------------------------------------------
// Records enter one per cycle and are placed in sorted position at once by a
// row of CAPACITY insertion cells; every cell compares its key with the
// incoming one in parallel, so collection runs at one transaction per clock.
// The record carrying batch_end is stored like any other, and then the row
// drains: cell 0 goes to the output register and the row shifts one place
// left each cycle the output is free, so the stored records are emitted in
// ascending order, waiting while res_stall is held. rec_stall is high for
// the whole drain. Records arriving with all cells full are dropped, and
// every result of that batch then shows dropped_flag. The row is empty again
// once the final record has left it, with no separate clearing step.
// ----------------------------------------------------------------------------
module multikey_record_sorter_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // record input
  input  logic                          rec_valid,
  output logic                          rec_stall,
  input  logic [mrs_pkg::COLLEGE_W-1:0] college_id,
  input  logic [mrs_pkg::DEPT_W-1:0]    department_id,
  input  logic [mrs_pkg::MEMBER_W-1:0]  member_number,
  input  logic                          batch_end,
  // sorted result output
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [mrs_pkg::COLLEGE_W-1:0] out_college,
  output logic [mrs_pkg::DEPT_W-1:0]    out_department,
  output logic [mrs_pkg::MEMBER_W-1:0]  out_member,
  output logic                          out_final,
  output logic                          dropped_flag
);

  // links[i] is the left neighbor of cell i; cell i drives links[i+1]
  mrs_pkg::link_t links [CAPACITY+1];
  mrs_pkg::link_t empty_link;
  mrs_pkg::key_t  new_key;

  logic draining;
  logic overflow;
  logic accept;
  logic full;
  logic ins;
  logic load;
  logic last_out;

  assign new_key = {college_id, department_id, member_number};

  assign rec_stall = draining;
  assign accept    = rec_valid && !rec_stall;
  assign full      = links[CAPACITY].valid;
  assign ins       = accept && !full;

  // Output register free: pull cell 0 and shift the row.
  assign load      = draining && (!res_valid || !res_stall);
  // cell 1 empty means cell 0 holds the batch's largest record
  assign last_out  = !links[2].valid;

  // Virtual cell left of cell 0: occupied and never greater.
  assign links[0]   = '{valid: 1'b1, key: '0, gt: 1'b0};
  assign empty_link = '{valid: 1'b0, key: '0, gt: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mrs_pkg::link_t right;
    if (i == CAPACITY - 1) begin : g_end
      assign right = empty_link;
    end else begin : g_mid
      assign right = links[i+2];
    end
    mrs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ins     (ins),
      .shift   (load),
      .new_key (new_key),
      .left    (links[i]),
      .right   (right),
      .own     (links[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      overflow  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept && batch_end) begin
        draining <= 1'b1;
      end else if (load && last_out) begin
        draining <= 1'b0;
      end
      if (accept && full) begin
        overflow <= 1'b1;
      end else if (load && last_out) begin
        overflow <= 1'b0;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (load) begin
      out_college    <= links[1].key[mrs_pkg::KEY_W-1 -: mrs_pkg::COLLEGE_W];
      out_department <= links[1].key[mrs_pkg::MEMBER_W +: mrs_pkg::DEPT_W];
      out_member     <= links[1].key[mrs_pkg::MEMBER_W-1:0];
      out_final      <= last_out;
      dropped_flag   <= overflow;
    end
  end

  // ---- checks -------------------------------------------------------------
  logic [CAPACITY-1:0] vld;
  logic [CAPACITY-2:0] order_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_vld
    assign vld[i] = links[i+1].valid;
  end
  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_ord
    assign order_ok[i] = !links[i+2].valid || (links[i+1].key <= links[i+2].key);
  end

  // occupied cells form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld >> 1) & ~vld) == '0)
    else $error("cell occupancy has a gap");

  // occupied cells are kept in ascending order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("cell row out of order");

  // a drain always finds a record in cell 0
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> vld[0])
    else $error("drain with empty row");

  // batch_end starts a drain
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    accept && batch_end |=> draining)
    else $error("batch end did not start drain");

  // once the final record is loaded the row is empty and accepting
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    load && last_out |=> !draining && !vld[0] && !overflow)
    else $error("row not cleared after final record");

endmodule
